>>> rtl/core/vna_pkg.sv
// vna_pkg: shared types and constants of the vertex normal accumulator
// opcodes, controller states, datapath commands and status
// depends on nothing
`default_nettype none

package vna_pkg;

   localparam int MAX_VERTICES_DEFAULT = 1024;
   localparam int INDEX_W = 10;
   localparam int POS_W = 16;
   localparam int ACC_W = 48;
   localparam int NORMAL_W = 16;
   localparam int UNIT_Q14 = 16384;

   typedef enum logic [1:0] {
      OP_WRITE    = 2'd0,
      OP_TRIANGLE = 2'd1,
      OP_READ     = 2'd2,
      OP_CLEAR    = 2'd3
   } opcode_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_POS_WRITE,
      ST_T_PA,
      ST_T_PB,
      ST_T_PC,
      ST_T_PW,
      ST_T_MUL,
      ST_T_CHK,
      ST_S_RD,
      ST_S_WR,
      ST_R_RD,
      ST_R_LD,
      ST_R_CHK,
      ST_R_NORM,
      ST_R_SQ,
      ST_R_SQI,
      ST_R_SQRT,
      ST_R_DVI,
      ST_R_DIV,
      ST_R_DVS,
      ST_R_FB,
      ST_R_OUT
   } state_type;

   typedef enum logic [4:0] {
      STEP_NONE,
      STEP_POS_WRITE,
      STEP_RD_A,
      STEP_RD_B,
      STEP_RD_C,
      STEP_CAP_C,
      STEP_CROSS,
      STEP_TRI_CHK,
      STEP_SUM_RD,
      STEP_SUM_WR,
      STEP_NRM_RD,
      STEP_NRM_LD,
      STEP_NORM,
      STEP_SQUARE,
      STEP_SQRT_INIT,
      STEP_SQRT,
      STEP_DIV_INIT,
      STEP_DIV,
      STEP_DIV_STORE,
      STEP_FALLBACK,
      STEP_CLEAR
   } step_type;

   typedef struct packed {
      logic     load;
      step_type step;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       wr_ok;
      logic       tri_ok;
      logic       rd_ok;
      logic       cnt_last;
      logic       clr_last;
      logic       cross_zero;
      logic       mag_zero;
      logic       mag_high;
      logic       mag_low;
      logic       vsel_last;
      logic       k_last;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/vna_ram.sv
// vna_ram: generic simple dual-port ram, one write and one registered read
// depends on nothing
`default_nettype none

module vna_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/vna_ctrl.sv
// vna_ctrl: controller state machine of the vertex normal accumulator
// depends on vna_pkg; drives datapath commands from datapath status
`default_nettype none

module vna_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire vna_pkg::status_type  status,
   output vna_pkg::cmd_type          cmd,
   output logic                      busy,
   output logic                      rsp_valid
);

   vna_pkg::state_type state_ff;
   vna_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vna_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vna_pkg::ST_CLEAR: begin
            if (status.clr_last) state_in = vna_pkg::ST_IDLE;
         end
         vna_pkg::ST_IDLE: begin
            if (start) state_in = vna_pkg::ST_DISPATCH;
         end
         vna_pkg::ST_DISPATCH: begin
            case (status.op)
               vna_pkg::OP_WRITE:
                  state_in = status.wr_ok ? vna_pkg::ST_POS_WRITE : vna_pkg::ST_IDLE;
               vna_pkg::OP_TRIANGLE:
                  state_in = status.tri_ok ? vna_pkg::ST_T_PA : vna_pkg::ST_IDLE;
               vna_pkg::OP_READ:
                  state_in = status.rd_ok ? vna_pkg::ST_R_RD : vna_pkg::ST_R_FB;
               vna_pkg::OP_CLEAR:
                  state_in = vna_pkg::ST_CLEAR;
               default:
                  state_in = vna_pkg::ST_IDLE;
            endcase
         end
         vna_pkg::ST_POS_WRITE: state_in = vna_pkg::ST_IDLE;
         vna_pkg::ST_T_PA:      state_in = vna_pkg::ST_T_PB;
         vna_pkg::ST_T_PB:      state_in = vna_pkg::ST_T_PC;
         vna_pkg::ST_T_PC:      state_in = vna_pkg::ST_T_PW;
         vna_pkg::ST_T_PW:      state_in = vna_pkg::ST_T_MUL;
         vna_pkg::ST_T_MUL: begin
            if (status.cnt_last) state_in = vna_pkg::ST_T_CHK;
         end
         vna_pkg::ST_T_CHK: begin
            state_in = status.cross_zero ? vna_pkg::ST_IDLE : vna_pkg::ST_S_RD;
         end
         vna_pkg::ST_S_RD: state_in = vna_pkg::ST_S_WR;
         vna_pkg::ST_S_WR: begin
            state_in = status.vsel_last ? vna_pkg::ST_IDLE : vna_pkg::ST_S_RD;
         end
         vna_pkg::ST_R_RD: state_in = vna_pkg::ST_R_LD;
         vna_pkg::ST_R_LD: state_in = vna_pkg::ST_R_CHK;
         vna_pkg::ST_R_CHK: begin
            state_in = status.mag_zero ? vna_pkg::ST_R_FB : vna_pkg::ST_R_NORM;
         end
         vna_pkg::ST_R_NORM: begin
            if (!status.mag_high && !status.mag_low) state_in = vna_pkg::ST_R_SQ;
         end
         vna_pkg::ST_R_SQ: begin
            if (status.cnt_last) state_in = vna_pkg::ST_R_SQI;
         end
         vna_pkg::ST_R_SQI: state_in = vna_pkg::ST_R_SQRT;
         vna_pkg::ST_R_SQRT: begin
            if (status.cnt_last) state_in = vna_pkg::ST_R_DVI;
         end
         vna_pkg::ST_R_DVI: state_in = vna_pkg::ST_R_DIV;
         vna_pkg::ST_R_DIV: begin
            if (status.cnt_last) state_in = vna_pkg::ST_R_DVS;
         end
         vna_pkg::ST_R_DVS: begin
            state_in = status.k_last ? vna_pkg::ST_R_OUT : vna_pkg::ST_R_DVI;
         end
         vna_pkg::ST_R_FB:  state_in = vna_pkg::ST_R_OUT;
         vna_pkg::ST_R_OUT: state_in = vna_pkg::ST_IDLE;
         default:           state_in = vna_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != vna_pkg::ST_IDLE);
      rsp_valid = (state_ff == vna_pkg::ST_R_OUT);
      cmd.load  = (state_ff == vna_pkg::ST_IDLE) && start;
      case (state_ff)
         vna_pkg::ST_CLEAR:     cmd.step = vna_pkg::STEP_CLEAR;
         vna_pkg::ST_POS_WRITE: cmd.step = vna_pkg::STEP_POS_WRITE;
         vna_pkg::ST_T_PA:      cmd.step = vna_pkg::STEP_RD_A;
         vna_pkg::ST_T_PB:      cmd.step = vna_pkg::STEP_RD_B;
         vna_pkg::ST_T_PC:      cmd.step = vna_pkg::STEP_RD_C;
         vna_pkg::ST_T_PW:      cmd.step = vna_pkg::STEP_CAP_C;
         vna_pkg::ST_T_MUL:     cmd.step = vna_pkg::STEP_CROSS;
         vna_pkg::ST_T_CHK:     cmd.step = vna_pkg::STEP_TRI_CHK;
         vna_pkg::ST_S_RD:      cmd.step = vna_pkg::STEP_SUM_RD;
         vna_pkg::ST_S_WR:      cmd.step = vna_pkg::STEP_SUM_WR;
         vna_pkg::ST_R_RD:      cmd.step = vna_pkg::STEP_NRM_RD;
         vna_pkg::ST_R_LD:      cmd.step = vna_pkg::STEP_NRM_LD;
         vna_pkg::ST_R_NORM:    cmd.step = vna_pkg::STEP_NORM;
         vna_pkg::ST_R_SQ:      cmd.step = vna_pkg::STEP_SQUARE;
         vna_pkg::ST_R_SQI:     cmd.step = vna_pkg::STEP_SQRT_INIT;
         vna_pkg::ST_R_SQRT:    cmd.step = vna_pkg::STEP_SQRT;
         vna_pkg::ST_R_DVI:     cmd.step = vna_pkg::STEP_DIV_INIT;
         vna_pkg::ST_R_DIV:     cmd.step = vna_pkg::STEP_DIV;
         vna_pkg::ST_R_DVS:     cmd.step = vna_pkg::STEP_DIV_STORE;
         vna_pkg::ST_R_FB:      cmd.step = vna_pkg::STEP_FALLBACK;
         default:               cmd.step = vna_pkg::STEP_NONE;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/vna_datapath.sv
// vna_datapath: position and accumulator rams, shared multiplier,
// bit-serial square root and divider; depends on vna_pkg and vna_ram
`default_nettype none

module vna_datapath #(
   parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire vna_pkg::cmd_type                      cmd,
   output vna_pkg::status_type                        status,
   input  wire logic [1:0]                            req_opcode,
   input  wire logic [vna_pkg::INDEX_W-1:0]           req_vertex_a,
   input  wire logic [vna_pkg::INDEX_W-1:0]           req_vertex_b,
   input  wire logic [vna_pkg::INDEX_W-1:0]           req_vertex_c,
   input  wire logic signed [vna_pkg::POS_W-1:0]      req_pos_x,
   input  wire logic signed [vna_pkg::POS_W-1:0]      req_pos_y,
   input  wire logic signed [vna_pkg::POS_W-1:0]      req_pos_z,
   output logic signed [vna_pkg::NORMAL_W-1:0]        rsp_normal_x,
   output logic signed [vna_pkg::NORMAL_W-1:0]        rsp_normal_y,
   output logic signed [vna_pkg::NORMAL_W-1:0]        rsp_normal_z,
   output logic                                       rsp_used_fallback
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int IW = vna_pkg::INDEX_W;
   localparam int PW = vna_pkg::POS_W;
   localparam int CW = vna_pkg::ACC_W;
   localparam int NW = vna_pkg::NORMAL_W;

   // captured transaction
   vna_pkg::opcode_type op_ff, op_in;
   logic [IW-1:0]   va_ff, va_in, vb_ff, vb_in, vc_ff, vc_in;
   logic [3*PW-1:0] pw_ff, pw_in;

   // triangle
   logic [3*PW-1:0]     pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   logic signed [34:0]  n_ff [3];
   logic signed [34:0]  n_in [3];
   logic signed [63:0]  prod_ff, prod_in;

   // counters
   logic [4:0]    cnt_ff, cnt_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0]    vsel_ff, vsel_in;
   logic [1:0]    kdiv_ff, kdiv_in;

   // normalize
   logic [CW-1:0] mag_ff [3];
   logic [CW-1:0] mag_in [3];
   logic [2:0]    neg_ff, neg_in;
   logic [61:0]   l2_ff, l2_in;
   logic [61:0]   rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [44:0]   drem_ff, drem_in, dsr_ff, dsr_in;
   logic [14:0]   q_ff, q_in;
   logic [NW-1:0] out_ff [3];
   logic [NW-1:0] out_in [3];
   logic          fb_ff, fb_in;

   // rams
   logic            pos_we;
   logic [AW-1:0]   pos_waddr, pos_raddr;
   logic [3*PW-1:0] pos_rdata;
   logic            sum_we;
   logic [AW-1:0]   sum_waddr, sum_raddr;
   logic [3*CW-1:0] sum_wdata, sum_rdata;

   logic signed [16:0] e1 [3];
   logic signed [16:0] e2 [3];
   logic signed [31:0] mul_a, mul_b;
   logic [IW-1:0]      vsel_idx;
   logic [3*CW-1:0]    sat_word;
   logic [CW:0]        sum_wide [3];
   logic [2:0]         jdx;
   logic [62:0]        sq_trial;
   logic [14:0]        q_clamp;
   logic [CW-1:0]      mag_k;
   logic [4:0]         cnt_limit;

   vna_ram #(.WIDTH(3 * PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (pw_ff),
      .rd_addr (pos_raddr),
      .rd_data (pos_rdata)
   );

   vna_ram #(.WIDTH(3 * CW), .DEPTH(MAX_VERTICES)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_addr (sum_raddr),
      .rd_data (sum_rdata)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1[i] = 17'(signed'(pb_ff[PW*i +: PW])) - 17'(signed'(pa_ff[PW*i +: PW]));
         e2[i] = 17'(signed'(pc_ff[PW*i +: PW])) - 17'(signed'(pa_ff[PW*i +: PW]));
      end
   end

   always_comb begin
      case (vsel_ff)
         2'd0:    vsel_idx = va_ff;
         2'd1:    vsel_idx = vb_ff;
         default: vsel_idx = vc_ff;
      endcase
      case (kdiv_ff)
         2'd0:    mag_k = mag_ff[0];
         2'd1:    mag_k = mag_ff[1];
         default: mag_k = mag_ff[2];
      endcase
   end

   // saturating accumulate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_wide[i] = (CW + 1)'(signed'(sum_rdata[CW*i +: CW])) + (CW + 1)'(n_ff[i]);
         if (sum_wide[i][CW] != sum_wide[i][CW-1]) begin
            sat_word[CW*i +: CW] = sum_wide[i][CW] ? {1'b1, {(CW-1){1'b0}}}
                                                   : {1'b0, {(CW-1){1'b1}}};
         end else begin
            sat_word[CW*i +: CW] = sum_wide[i][CW-1:0];
         end
      end
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.step == vna_pkg::STEP_CROSS) begin
         case (cnt_ff)
            5'd0:    begin mul_a = 32'(e1[1]); mul_b = 32'(e2[2]); end
            5'd1:    begin mul_a = 32'(e1[2]); mul_b = 32'(e2[1]); end
            5'd2:    begin mul_a = 32'(e1[2]); mul_b = 32'(e2[0]); end
            5'd3:    begin mul_a = 32'(e1[0]); mul_b = 32'(e2[2]); end
            5'd4:    begin mul_a = 32'(e1[0]); mul_b = 32'(e2[1]); end
            5'd5:    begin mul_a = 32'(e1[1]); mul_b = 32'(e2[0]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else begin
         case (cnt_ff)
            5'd0:    begin mul_a = {2'b00, mag_ff[0][29:0]}; mul_b = {2'b00, mag_ff[0][29:0]}; end
            5'd1:    begin mul_a = {2'b00, mag_ff[1][29:0]}; mul_b = {2'b00, mag_ff[1][29:0]}; end
            5'd2:    begin mul_a = {2'b00, mag_ff[2][29:0]}; mul_b = {2'b00, mag_ff[2][29:0]}; end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end

   always_comb begin
      op_in   = op_ff;
      va_in   = va_ff;
      vb_in   = vb_ff;
      vc_in   = vc_ff;
      pw_in   = pw_ff;
      pa_in   = pa_ff;
      pb_in   = pb_ff;
      pc_in   = pc_ff;
      n_in    = n_ff;
      prod_in = mul_a * mul_b;
      cnt_in  = 5'd0;
      clr_in  = '0;
      vsel_in = vsel_ff;
      kdiv_in = kdiv_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      l2_in   = l2_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      drem_in = drem_ff;
      dsr_in  = dsr_ff;
      q_in    = q_ff;
      out_in  = out_ff;
      fb_in   = fb_ff;
      jdx     = cnt_ff[2:0] - 3'd1;
      sq_trial = 63'(rem_ff) - (63'(res_ff) + 63'(bit_ff));
      q_clamp = (q_ff > 15'(vna_pkg::UNIT_Q14)) ? 15'(vna_pkg::UNIT_Q14) : q_ff;

      pos_we    = 1'b0;
      pos_waddr = AW'(va_ff);
      pos_raddr = AW'(va_ff);
      sum_we    = 1'b0;
      sum_waddr = AW'(vsel_idx);
      sum_raddr = AW'(vsel_idx);
      sum_wdata = sat_word;

      if (cmd.load) begin
         op_in = vna_pkg::opcode_type'(req_opcode);
         va_in = req_vertex_a;
         vb_in = req_vertex_b;
         vc_in = req_vertex_c;
         pw_in = {req_pos_z, req_pos_y, req_pos_x};
      end

      case (cmd.step)
         vna_pkg::STEP_POS_WRITE: pos_we = 1'b1;
         vna_pkg::STEP_RD_A: pos_raddr = AW'(va_ff);
         vna_pkg::STEP_RD_B: begin
            pos_raddr = AW'(vb_ff);
            pa_in     = pos_rdata;
         end
         vna_pkg::STEP_RD_C: begin
            pos_raddr = AW'(vc_ff);
            pb_in     = pos_rdata;
         end
         vna_pkg::STEP_CAP_C: pc_in = pos_rdata;
         vna_pkg::STEP_CROSS: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff != 5'd0) begin
               if (!jdx[0]) begin
                  n_in[jdx[2:1]] = prod_ff[34:0];
               end else begin
                  n_in[jdx[2:1]] = n_ff[jdx[2:1]] - prod_ff[34:0];
               end
            end
         end
         vna_pkg::STEP_TRI_CHK: vsel_in = 2'd0;
         vna_pkg::STEP_SUM_RD: sum_raddr = AW'(vsel_idx);
         vna_pkg::STEP_SUM_WR: begin
            sum_we  = 1'b1;
            vsel_in = vsel_ff + 2'd1;
         end
         vna_pkg::STEP_NRM_RD: sum_raddr = AW'(va_ff);
         vna_pkg::STEP_NRM_LD: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = sum_rdata[CW*i + CW - 1];
               mag_in[i] = neg_in[i] ? (~sum_rdata[CW*i +: CW] + CW'(1))
                                     : sum_rdata[CW*i +: CW];
            end
         end
         vna_pkg::STEP_NORM: begin
            if (status.mag_high) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (status.mag_low) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end
         end
         vna_pkg::STEP_SQUARE: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd1) begin
               l2_in = prod_ff[61:0];
            end else if (cnt_ff != 5'd0) begin
               l2_in = l2_ff + prod_ff[61:0];
            end
         end
         vna_pkg::STEP_SQRT_INIT: begin
            rem_in  = l2_ff;
            res_in  = '0;
            bit_in  = 62'd1 << 60;
            kdiv_in = 2'd0;
            fb_in   = 1'b0;
         end
         vna_pkg::STEP_SQRT: begin
            cnt_in = cnt_ff + 5'd1;
            if (!sq_trial[62]) begin
               rem_in = sq_trial[61:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         vna_pkg::STEP_DIV_INIT: begin
            drem_in = {1'b0, mag_k[29:0], 14'd0} + 45'(res_ff[30:1]);
            dsr_in  = {res_ff[30:0], 14'd0};
            q_in    = '0;
         end
         vna_pkg::STEP_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (drem_ff >= dsr_ff) begin
               drem_in = drem_ff - dsr_ff;
               q_in    = {q_ff[13:0], 1'b1};
            end else begin
               q_in    = {q_ff[13:0], 1'b0};
            end
            dsr_in = dsr_ff >> 1;
         end
         vna_pkg::STEP_DIV_STORE: begin
            out_in[kdiv_ff] = neg_ff[kdiv_ff] ? (~NW'(q_clamp) + NW'(1)) : NW'(q_clamp);
            kdiv_in = kdiv_ff + 2'd1;
         end
         vna_pkg::STEP_FALLBACK: begin
            out_in[0] = '0;
            out_in[1] = NW'(vna_pkg::UNIT_Q14);
            out_in[2] = '0;
            fb_in     = 1'b1;
         end
         vna_pkg::STEP_CLEAR: begin
            clr_in    = clr_ff + AW'(1);
            sum_we    = 1'b1;
            sum_waddr = clr_ff;
            sum_wdata = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 5'd0;
         clr_ff  <= '0;
         vsel_ff <= 2'd0;
         kdiv_ff <= 2'd0;
      end else begin
         cnt_ff  <= cnt_in;
         clr_ff  <= clr_in;
         vsel_ff <= vsel_in;
         kdiv_ff <= kdiv_in;
      end
      op_ff   <= op_in;
      va_ff   <= va_in;
      vb_ff   <= vb_in;
      vc_ff   <= vc_in;
      pw_ff   <= pw_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      pc_ff   <= pc_in;
      n_ff    <= n_in;
      prod_ff <= prod_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      l2_ff   <= l2_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      drem_ff <= drem_in;
      dsr_ff  <= dsr_in;
      q_ff    <= q_in;
      out_ff  <= out_in;
      fb_ff   <= fb_in;
   end

   always_comb begin
      case (cmd.step)
         vna_pkg::STEP_CROSS:  cnt_limit = 5'd6;
         vna_pkg::STEP_SQUARE: cnt_limit = 5'd3;
         vna_pkg::STEP_SQRT:   cnt_limit = 5'd30;
         vna_pkg::STEP_DIV:    cnt_limit = 5'd14;
         default:              cnt_limit = 5'd0;
      endcase
      status.op         = op_ff;
      status.wr_ok      = 32'(va_ff) < MAX_VERTICES;
      status.rd_ok      = 32'(va_ff) < MAX_VERTICES;
      status.tri_ok     = (32'(va_ff) < MAX_VERTICES) && (32'(vb_ff) < MAX_VERTICES)
                          && (32'(vc_ff) < MAX_VERTICES);
      status.cnt_last   = (cnt_ff == cnt_limit);
      status.clr_last   = (clr_ff == AW'(MAX_VERTICES - 1));
      status.cross_zero = (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
      status.mag_zero   = (mag_ff[0] == '0) && (mag_ff[1] == '0) && (mag_ff[2] == '0);
      status.mag_high   = (|mag_ff[0][CW-1:30]) || (|mag_ff[1][CW-1:30])
                          || (|mag_ff[2][CW-1:30]);
      status.mag_low    = !(|mag_ff[0][CW-1:29]) && !(|mag_ff[1][CW-1:29])
                          && !(|mag_ff[2][CW-1:29]);
      status.vsel_last  = (vsel_ff == 2'd2);
      status.k_last     = (kdiv_ff == 2'd2);
   end

   assign rsp_normal_x      = out_ff[0];
   assign rsp_normal_y      = out_ff[1];
   assign rsp_normal_z      = out_ff[2];
   assign rsp_used_fallback = fb_ff;

endmodule

`default_nettype wire

>>> rtl/core/vertex_normal_accumulator.sv
// vertex_normal_accumulator: area weighted per-vertex normals of a triangle mesh
// top level; depends on vna_pkg, vna_ctrl, vna_datapath (and vna_ram below it)
//
//   channel   handshake                 payload
//   request   start high, busy low      req_opcode, req_vertex_a/b/c, req_pos_x/y/z
//   response  rsp_valid, one cycle      rsp_normal_x/y/z, rsp_used_fallback
//
// triangle: three position reads, six products on one multiplier, three accumulator
// read-modify-writes; the read-modify-writes are skipped when degenerate
// read normal: shift search of up to 29 steps, the 31-step square root and three
// 15-step divisions; a zero accumulator skips them and takes the fallback
// clear: zeroes all MAX_VERTICES accumulator entries; reset starts the same pass
// a transaction is taken only while busy is low; the receiver cannot stall a response
`default_nettype none

module vertex_normal_accumulator #(
   parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_opcode,
   input  wire logic [vna_pkg::INDEX_W-1:0]       req_vertex_a,
   input  wire logic [vna_pkg::INDEX_W-1:0]       req_vertex_b,
   input  wire logic [vna_pkg::INDEX_W-1:0]       req_vertex_c,
   input  wire logic signed [vna_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic signed [vna_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic signed [vna_pkg::POS_W-1:0]  req_pos_z,
   output logic                                   rsp_valid,
   output logic signed [vna_pkg::NORMAL_W-1:0]    rsp_normal_x,
   output logic signed [vna_pkg::NORMAL_W-1:0]    rsp_normal_y,
   output logic signed [vna_pkg::NORMAL_W-1:0]    rsp_normal_z,
   output logic                                   rsp_used_fallback
);

   vna_pkg::cmd_type    cmd;
   vna_pkg::status_type status;

   vna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   vna_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_vertex_a      (req_vertex_a),
      .req_vertex_b      (req_vertex_b),
      .req_vertex_c      (req_vertex_c),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_normal_z      (rsp_normal_z),
      .rsp_used_fallback (rsp_used_fallback)
   );

endmodule

`default_nettype wire
